[rtl/core/ahfe_pkg.sv]
// Shared types, constants and helpers of the ASCII hex frame encoder.
package ahfe_pkg;

    localparam int unsigned FIFO_DEPTH_DEFAULT = 4;
    localparam int unsigned HEX_BYTES = 5;

    typedef enum logic
    {
        MODE_HEADER = 1'b0,
        MODE_DATA   = 1'b1
    } mode_t;

    typedef enum logic
    {
        REG_POLL_TYPE = 1'b0,
        REG_USER_TYPE = 1'b1
    } reg_index_t;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;

    localparam logic [3:0] BODY_HEADER_USER  = 4'd11;
    localparam logic [3:0] BODY_HEADER_PLAIN = 4'd5;
    localparam logic [3:0] BODY_DATA_HEX     = 4'd2;
    localparam logic [3:0] BODY_NONE         = 4'd0;
    localparam logic [3:0] TAIL_LEN          = 4'd4;

    localparam logic [1:0] TAIL_SUM_HI = 2'd0;
    localparam logic [1:0] TAIL_SUM_LO = 2'd1;
    localparam logic [1:0] TAIL_CR     = 2'd2;
    localparam logic [1:0] TAIL_LF     = 2'd3;

    typedef struct packed
    {
        logic                            lead;
        logic [7:0]                      lead_char;
        logic [HEX_BYTES-1:0][7:0]       hex_bytes;
        logic [3:0]                      body_len;
        logic                            tail;
        logic [7:0]                      checksum;
    } cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib > 4'd9)
        begin
            c = CHAR_A + {4'd0, nib} - 8'd10;
        end
        else
        begin
            c = CHAR_ZERO + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

[rtl/core/ascii_hex_frame_encoder.sv]
// Top level of the ASCII hex frame encoder.
//
// Turns header and data items into ASCII hex frame characters, one per cycle
// on the output channel while out_ready is high. The front end takes one item
// per cycle as long as the command queue (FIFO_DEPTH entries) has room; the
// character sequencer behind it sets the throughput: a data byte of a user
// frame gives two characters, a frame tail four more, a header five (or eleven
// for a user message) plus the tail when no data follows. Items that emit
// nothing push no command. The output register is refilled in the same cycle
// its character is taken, so characters leave with no gap while out_ready is high.
module ascii_hex_frame_encoder
#(
    parameter int unsigned FIFO_DEPTH = ahfe_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  link_dest,
    input  logic [7:0]  link_src,
    input  logic [7:0]  msg_type,
    input  logic [7:0]  node_src,
    input  logic [7:0]  node_dest,
    input  logic [7:0]  data_len,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        frame_end
);
    import ahfe_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    ahfe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .mode      (mode),
        .link_dest (link_dest),
        .link_src  (link_src),
        .msg_type  (msg_type),
        .node_src  (node_src),
        .node_dest (node_dest),
        .data_len  (data_len),
        .data_byte (data_byte),
        .push      (push),
        .cmd       (push_cmd)
    );

    ahfe_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head_cmd (head_cmd)
    );

    ahfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .frame_end (frame_end)
    );

endmodule

[rtl/core/ahfe_front.sv]
// Front end: accepts items, keeps frame state and issues character commands.
module ahfe_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               accept,
    input  logic               mode,
    input  logic [7:0]         link_dest,
    input  logic [7:0]         link_src,
    input  logic [7:0]         msg_type,
    input  logic [7:0]         node_src,
    input  logic [7:0]         node_dest,
    input  logic [7:0]         data_len,
    input  logic [7:0]         data_byte,
    output logic               push,
    output ahfe_pkg::cmd_t     cmd
);
    import ahfe_pkg::*;

    logic [7:0] poll_code_reg;
    logic [7:0] user_code_reg;
    logic [7:0] checksum_reg;
    logic [7:0] checksum_next;
    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       user_open_reg;
    logic       user_open_next;
    logic       sum_data_reg;
    logic       sum_data_next;

    logic       is_poll;
    logic       is_user;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_code_reg <= 8'd0;
            user_code_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_POLL_TYPE: poll_code_reg <= cfg_data;
                REG_USER_TYPE: user_code_reg <= cfg_data;
                default:       poll_code_reg <= poll_code_reg;
            endcase
        end
    end

    assign is_poll = (msg_type == poll_code_reg);
    assign is_user = (msg_type == user_code_reg);

    always_comb
    begin
        checksum_next  = checksum_reg;
        pending_next   = pending_reg;
        user_open_next = user_open_reg;
        sum_data_next  = sum_data_reg;
        push           = 1'b0;
        cmd.lead       = 1'b0;
        cmd.lead_char  = link_dest + CHAR_ZERO;
        cmd.hex_bytes  = {link_src, msg_type, node_src, node_dest, data_len};
        cmd.body_len   = BODY_NONE;
        cmd.tail       = 1'b0;
        cmd.checksum   = checksum_reg;

        if (accept)
        begin
            if (mode_t'(mode) == MODE_HEADER)
            begin
                if (is_poll)
                begin
                    checksum_next = link_dest + link_src;
                end
                else
                begin
                    checksum_next = link_dest + link_src + msg_type + node_src
                                  + node_dest + data_len;
                end
                sum_data_next  = !is_poll;
                user_open_next = is_user;
                pending_next   = (is_user || !is_poll) ? data_len : 8'd0;
                push           = 1'b1;
                cmd.lead       = 1'b1;
                cmd.body_len   = is_user ? BODY_HEADER_USER : BODY_HEADER_PLAIN;
            end
            else if (pending_reg != 8'd0)
            begin
                if (sum_data_reg)
                begin
                    checksum_next = checksum_reg + data_byte;
                end
                pending_next  = pending_reg - 8'd1;
                cmd.hex_bytes = {data_byte, data_byte, data_byte, data_byte, data_byte};
                cmd.body_len  = user_open_reg ? BODY_DATA_HEX : BODY_NONE;
                push          = user_open_reg || (pending_next == 8'd0);
            end

            cmd.checksum = checksum_next;
            if (pending_next == 8'd0 && push)
            begin
                cmd.tail       = 1'b1;
                user_open_next = 1'b0;
                sum_data_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checksum_reg  <= 8'd0;
            pending_reg   <= 8'd0;
            user_open_reg <= 1'b0;
            sum_data_reg  <= 1'b0;
        end
        else
        begin
            checksum_reg  <= checksum_next;
            pending_reg   <= pending_next;
            user_open_reg <= user_open_next;
            sum_data_reg  <= sum_data_next;
        end
    end

endmodule

[rtl/core/ahfe_fifo.sv]
// Command queue between the front end and the character sequencer.
module ahfe_fifo
#(
    parameter int unsigned DEPTH = ahfe_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ahfe_pkg::cmd_t     push_cmd,
    input  logic               pop,
    output logic               full,
    output logic               empty,
    output ahfe_pkg::cmd_t     head_cmd
);
    import ahfe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             cmd_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = cmd_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/ahfe_back.sv]
// Back end: steps through each command and emits one character per cycle while out_ready is high.
module ahfe_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  ahfe_pkg::cmd_t     head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_char,
    output logic               frame_end
);
    import ahfe_pkg::*;

    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       frame_end_reg;

    logic       advance;
    logic [3:0] total;
    logic       last;
    logic       in_body;
    logic [3:0] hex_pos;
    logic [7:0] sel_byte;
    logic [1:0] tail_pos;
    logic [7:0] char_next;
    logic       end_next;

    assign advance = !out_valid_reg || out_ready;
    assign total   = head_cmd.body_len + (head_cmd.tail ? TAIL_LEN : BODY_NONE);
    assign last    = (step_reg == total - 4'd1);
    assign in_body = (step_reg < head_cmd.body_len);
    assign hex_pos = step_reg - {3'd0, head_cmd.lead};
    assign tail_pos = 2'(step_reg - head_cmd.body_len);
    assign pop     = advance && !empty && last;

    always_comb
    begin
        case (hex_pos[3:1])
            3'd0:    sel_byte = head_cmd.hex_bytes[4];
            3'd1:    sel_byte = head_cmd.hex_bytes[3];
            3'd2:    sel_byte = head_cmd.hex_bytes[2];
            3'd3:    sel_byte = head_cmd.hex_bytes[1];
            3'd4:    sel_byte = head_cmd.hex_bytes[0];
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        end_next = 1'b0;
        if (in_body)
        begin
            if (head_cmd.lead && step_reg == 4'd0)
            begin
                char_next = head_cmd.lead_char;
            end
            else
            begin
                char_next = hex_pos[0] ? hex_char(sel_byte[3:0]) : hex_char(sel_byte[7:4]);
            end
        end
        else
        begin
            unique case (tail_pos)
                TAIL_SUM_HI: char_next = hex_char(head_cmd.checksum[7:4]);
                TAIL_SUM_LO: char_next = hex_char(head_cmd.checksum[3:0]);
                TAIL_CR:     char_next = CHAR_CR;
                TAIL_LF:
                begin
                    char_next = CHAR_LF;
                    end_next  = 1'b1;
                end
                default:     char_next = CHAR_LF;
            endcase
        end
    end

    always_comb
    begin
        step_next = step_reg;
        if (advance && !empty)
        begin
            step_next = last ? 4'd0 : step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (advance)
            begin
                out_valid_reg <= !empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !empty)
        begin
            out_char_reg  <= char_next;
            frame_end_reg <= end_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign frame_end = frame_end_reg;

endmodule

[tb/frame_checker.sv]
// Checker that predicts the ASCII frame characters and compares them on the output channel.
`timescale 1ns / 1ps

module frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  link_dest,
    input  logic [7:0]  link_src,
    input  logic [7:0]  msg_type,
    input  logic [7:0]  node_src,
    input  logic [7:0]  node_dest,
    input  logic [7:0]  data_len,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_char,
    input  logic        frame_end,
    output int          err_count,
    output int          chars_outstanding
);
    import ahfe_pkg::*;

    typedef struct packed
    {
        logic [7:0] ch;
        logic       last;
    } frame_char_t;

    frame_char_t frame_chars[$];

    logic [7:0] poll_code;
    logic [7:0] user_code;
    logic [7:0] run_sum;
    logic [7:0] bytes_left;
    logic       hex_payload;
    logic       sum_payload;

    initial
    begin
        err_count = 0;
        chars_outstanding = 0;
    end

    function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = CHAR_ZERO + {4'd0, nib};
        end
        else
        begin
            c = CHAR_A - 8'd10 + {4'd0, nib};
        end
        return c;
    endfunction

    task automatic push_char(input logic [7:0] c, input logic last);
        frame_chars.push_back('{ch: c, last: last});
    endtask

    task automatic push_hex(input logic [7:0] v);
        push_char(nibble_ascii(v[7:4]), 1'b0);
        push_char(nibble_ascii(v[3:0]), 1'b0);
    endtask

    task automatic push_tail();
        push_hex(run_sum);
        push_char(CHAR_CR, 1'b0);
        push_char(CHAR_LF, 1'b1);
        hex_payload = 1'b0;
        sum_payload = 1'b0;
        bytes_left = 8'd0;
    endtask

    task automatic encode_item();
        logic is_poll;
        logic is_user;
        if (mode == MODE_HEADER)
        begin
            is_poll = (msg_type == poll_code);
            is_user = (msg_type == user_code);
            if (is_poll)
            begin
                run_sum = link_dest + link_src;
            end
            else
            begin
                run_sum = link_dest + link_src + msg_type + node_src + node_dest + data_len;
            end
            sum_payload = !is_poll;
            hex_payload = is_user;
            bytes_left = (is_user || !is_poll) ? data_len : 8'd0;
            push_char(link_dest + CHAR_ZERO, 1'b0);
            push_hex(link_src);
            push_hex(msg_type);
            if (is_user)
            begin
                push_hex(node_src);
                push_hex(node_dest);
                push_hex(data_len);
            end
            if (bytes_left == 8'd0)
            begin
                push_tail();
            end
        end
        else if (bytes_left != 8'd0)
        begin
            if (sum_payload)
            begin
                run_sum = run_sum + data_byte;
            end
            if (hex_payload)
            begin
                push_hex(data_byte);
            end
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0)
            begin
                push_tail();
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_char_t want;
        if (!rst_n)
        begin
            poll_code = 8'd0;
            user_code = 8'd1;
            run_sum = 8'd0;
            bytes_left = 8'd0;
            hex_payload = 1'b0;
            sum_payload = 1'b0;
            frame_chars.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_POLL_TYPE)
                begin
                    poll_code = cfg_data;
                end
                else
                begin
                    user_code = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                encode_item();
            end
            if (out_valid && out_ready)
            begin
                if (frame_chars.size() == 0)
                begin
                    $error("unexpected character 0x%02h (frame_end %0b)", out_char, frame_end);
                    err_count++;
                end
                else
                begin
                    want = frame_chars.pop_front();
                    if (out_char !== want.ch)
                    begin
                        $error("out_char: expected 0x%02h, got 0x%02h", want.ch, out_char);
                        err_count++;
                    end
                    if (frame_end !== want.last)
                    begin
                        $error("frame_end: expected %0b, got %0b", want.last, frame_end);
                        err_count++;
                    end
                end
            end
        end
        chars_outstanding = frame_chars.size();
    end

endmodule

[tb/tb_top.sv]
// Top of the frame encoder testbench: clock, reset, stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_top;
    import ahfe_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 32;
    localparam int ITEMS_PER_PHASE = 41;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [7:0]  link_dest;
    logic [7:0]  link_src;
    logic [7:0]  msg_type;
    logic [7:0]  node_src;
    logic [7:0]  node_dest;
    logic [7:0]  data_len;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_char;
    logic        frame_end;

    int          err_count;
    int          chars_outstanding;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_req_cnt;
    int          hold_done_cnt;
    int          items_done;
    int          cycle_count;
    logic [7:0]  cur_poll;
    logic [7:0]  cur_user;

    ascii_hex_frame_encoder u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .link_dest (link_dest),
        .link_src  (link_src),
        .msg_type  (msg_type),
        .node_src  (node_src),
        .node_dest (node_dest),
        .data_len  (data_len),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .frame_end (frame_end)
    );

    frame_checker u_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .link_dest         (link_dest),
        .link_src          (link_src),
        .msg_type          (msg_type),
        .node_src          (node_src),
        .node_dest         (node_dest),
        .data_len          (data_len),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_char          (out_char),
        .frame_end         (frame_end),
        .err_count         (err_count),
        .chars_outstanding (chars_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random stalls, plus a long hold-off on request
    initial
    begin
        hold_done_cnt = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req_cnt != hold_done_cnt)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                hold_done_cnt = hold_req_cnt;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic offer(input logic m, input logic [7:0] ldst, input logic [7:0] lsrc,
                         input logic [7:0] typ, input logic [7:0] nsrc,
                         input logic [7:0] ndst, input logic [7:0] len,
                         input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        link_dest <= ldst;
        link_src  <= lsrc;
        msg_type  <= typ;
        node_src  <= nsrc;
        node_dest <= ndst;
        data_len  <= len;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic hdr(input logic [7:0] ldst, input logic [7:0] lsrc, input logic [7:0] typ,
                       input logic [7:0] nsrc, input logic [7:0] ndst, input logic [7:0] len);
        offer(MODE_HEADER, ldst, lsrc, typ, nsrc, ndst, len, 8'($urandom_range(255)));
    endtask

    task automatic dat(input logic [7:0] b);
        offer(MODE_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 8'($urandom_range(255)), b);
    endtask

    // drop valid, drain every due character, then let trailing no-output items settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (chars_outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_codes(input logic [7:0] poll, input logic [7:0] user);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POLL_TYPE;
        cfg_data  <= poll;
        @(posedge clk);
        cfg_index <= REG_USER_TYPE;
        cfg_data  <= user;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_poll = poll;
        cur_user = user;
    endtask

    task automatic random_frame();
        int r;
        int len;
        int due;
        int n_data;
        logic [7:0] typ;
        r = $urandom_range(99);
        if (r < 35)
        begin
            typ = cur_user;
        end
        else if (r < 55)
        begin
            typ = cur_poll;
        end
        else
        begin
            typ = 8'($urandom_range(255));
        end
        len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6);
        due = (typ == cur_user || typ != cur_poll) ? len : 0;
        if (due > 12 || $urandom_range(9) == 0)
        begin
            n_data = $urandom_range((due < 6) ? due : 6);
        end
        else
        begin
            n_data = due;
        end
        if ($urandom_range(9) == 0)
        begin
            n_data += $urandom_range(1, 2);
        end
        hdr(8'($urandom_range(255)), 8'($urandom_range(255)), typ,
            8'($urandom_range(255)), 8'($urandom_range(255)), 8'(len));
        for (int i = 0; i < n_data; i++)
        begin
            dat(8'($urandom_range(255)));
        end
        items_done += 1 + ((n_data < due) ? n_data : due);
    endtask

    initial
    begin
        logic [7:0] poll;
        logic [7:0] user;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_POLL_TYPE;
        cfg_data = 8'd0;
        in_valid = 1'b0;
        mode = MODE_HEADER;
        link_dest = 8'd0;
        link_src = 8'd0;
        msg_type = 8'd0;
        node_src = 8'd0;
        node_dest = 8'd0;
        data_len = 8'd0;
        data_byte = 8'd0;
        send_idle_pct = 10;
        recv_idle_pct = 49;
        hold_req_cnt = 0;
        items_done = 0;
        cur_poll = 8'd0;
        cur_user = 8'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset codes: poll 0x00, user 0x01
        hdr(8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00);
        dat(8'hFF);
        hdr(8'h00, 8'hFF, 8'h00, 8'h5A, 8'hA5, 8'hFF);
        dat(8'h00);
        hdr(8'h12, 8'h34, 8'h01, 8'h56, 8'h78, 8'h02);
        dat(8'hFF);
        dat(8'h00);
        hdr(8'hFE, 8'hEF, 8'h7E, 8'h80, 8'h01, 8'h02);
        dat(8'hA5);
        dat(8'h5A);
        hdr(8'h80, 8'h7F, 8'hFF, 8'h00, 8'hFF, 8'h00);
        hdr(8'h01, 8'h02, 8'h01, 8'h03, 8'h04, 8'h03);
        dat(8'hC3);
        hdr(8'h9C, 8'h63, 8'h00, 8'h0F, 8'hF0, 8'h01);
        hdr(8'hAA, 8'h55, 8'h42, 8'h11, 8'h22, 8'h04);
        dat(8'h99);
        hdr(8'h01, 8'h01, 8'h01, 8'hC0, 8'h3F, 8'h01);
        dat(8'h7F);
        wait_idle();

        // poll and user codes equal
        write_codes(8'h55, 8'h55);
        hdr(8'h3A, 8'hC5, 8'h55, 8'h81, 8'h7E, 8'h02);
        dat(8'hE7);
        dat(8'h18);
        hdr(8'h30, 8'hCF, 8'h55, 8'h24, 8'hDB, 8'h00);

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            send_idle_pct = (ph < 2) ? 10 : ((ph < 4) ? 49 : 0);
            recv_idle_pct = (ph < 2) ? 49 : ((ph < 4) ? 10 : 0);
            case (ph)
                0: begin poll = 8'h00; user = 8'h01; end
                1: begin poll = 8'hFF; user = 8'h00; end
                2: begin poll = 8'h00; user = 8'hFF; end
                3: begin poll = 8'hAA; user = 8'hAA; end
                default:
                begin
                    poll = 8'($urandom_range(255));
                    user = 8'($urandom_range(255));
                end
            endcase
            write_codes(poll, user);
            if (ph == 4)
            begin
                hold_req_cnt <= hold_req_cnt + 1;
            end
            while (items_done < ITEMS_PER_PHASE * (ph + 1))
            begin
                random_frame();
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && chars_outstanding == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/ahfe_pkg.sv
rtl/core/ahfe_front.sv
rtl/core/ahfe_fifo.sv
rtl/core/ahfe_back.sv
rtl/core/ascii_hex_frame_encoder.sv
tb/frame_checker.sv
tb/tb_top.sv
